FILE: hdl/integer_alu_with_flags_unit_defines.svh
// ----------------------------------------------------------------------------
// integer_alu_with_flags_unit_defines
// Assertion macros used by the integer ALU top-level design file.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define INTEGER_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IALU_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication, checked out of reset
`define IALU_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

FILE: hdl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// Operation codes and the lane record carried along the divide chain.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam logic [3:0] FN_ADD  = 4'd0;
  localparam logic [3:0] FN_SUB  = 4'd1;
  localparam logic [3:0] FN_MUL  = 4'd2;
  localparam logic [3:0] FN_DIV  = 4'd3;
  localparam logic [3:0] FN_W2N  = 4'd4;
  localparam logic [3:0] FN_ASH  = 4'd5;
  localparam logic [3:0] FN_LSH  = 4'd6;
  localparam logic [3:0] FN_NADD = 4'd7;
  localparam logic [3:0] FN_NSUB = 4'd8;
  localparam logic [3:0] FN_NMUL = 4'd9;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NCELL  = 32;

  typedef struct packed {
    logic        is_div;
    logic        neg;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic [31:0] res;
    logic        ovr;
    logic        cy;
  } lane_t;

endpackage

FILE: hdl/ialu_if.sv
// ----------------------------------------------------------------------------
// ialu_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface ialu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [31:0] src;
  logic signed [31:0] dst;
  logic signed [7:0]  shift_amount;
  logic               ovr_in;
  logic               carry_in;

  modport source (output valid, func, src, dst, shift_amount, ovr_in, carry_in,
                  input ready);
  modport sink   (input valid, func, src, dst, shift_amount, ovr_in, carry_in,
                  output ready);
endinterface

interface ialu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               ovr_out;
  logic               carry_out;

  modport source (output valid, result, ovr_out, carry_out, input ready);
  modport sink   (input valid, result, ovr_out, carry_out, output ready);
endinterface

FILE: hdl/ialu_front.sv
// ----------------------------------------------------------------------------
// ialu_front
// Decode stage: finish every non-divide operation, set up the divide lane.
// ----------------------------------------------------------------------------
module ialu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               vld_in,
  input  logic [3:0]         func,
  input  logic signed [31:0] src,
  input  logic signed [31:0] dst,
  input  logic signed [7:0]  shift_amount,
  input  logic               ovr_in,
  input  logic               carry_in,
  output logic               vld_r,
  output ialu_pkg::lane_t    lane_r
);

  logic               vld_nxt;
  ialu_pkg::lane_t    lane_nxt;
  logic [32:0]        add_w;
  logic [32:0]        sub_w;
  logic [16:0]        nadd_w;
  logic [16:0]        nsub_w;
  logic [15:0]        s16;
  logic [15:0]        d16;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] prod;
  logic               mul_ovr_w;
  logic               mul_ovr_n;
  logic [7:0]         mag;
  logic               big;
  logic [31:0]        sll_v;
  logic [31:0]        srl_v;
  logic [31:0]        sra_v;
  logic [31:0]        sext_s;
  logic [31:0]        r_ash;
  logic [31:0]        r_lsh;
  logic               div_bad;

  always_comb begin
    s16    = src[15:0];
    d16    = dst[15:0];
    add_w  = {1'b0, dst} + {1'b0, src};
    sub_w  = {1'b0, dst} + {1'b0, ~src} + 33'd1;
    nadd_w = {1'b0, d16} + {1'b0, s16};
    nsub_w = {1'b0, d16} + {1'b0, ~s16} + 17'd1;
    sext_s = {{16{s16[15]}}, s16};
    // one shared multiplier, narrow form takes sign-extended halves
    ma     = (func == ialu_pkg::FN_NMUL) ? $signed({{16{s16[15]}}, s16}) : src;
    mb     = (func == ialu_pkg::FN_NMUL) ? $signed({{16{d16[15]}}, d16}) : dst;
    prod   = ma * mb;
    mul_ovr_w = !((&prod[63:31]) || !(|prod[63:31]));
    mul_ovr_n = !((&prod[31:15]) || !(|prod[31:15]));
    // shift magnitude, -128 maps to 128
    mag    = shift_amount[7] ? (8'd0 - shift_amount) : shift_amount;
    big    = (mag >= 8'd32);
    sll_v  = big ? 32'd0 : (src << mag[4:0]);
    srl_v  = big ? 32'd0 : (src >> mag[4:0]);
    // keep both arms signed so the right shift fills with the sign
    sra_v  = big ? $signed({32{src[31]}}) : (src >>> mag[4:0]);
    if (shift_amount[7]) begin
      r_ash = sra_v;
      r_lsh = srl_v;
    end else if (shift_amount != 8'sd0) begin
      r_ash = sll_v;
      r_lsh = sll_v;
    end else begin
      r_ash = src;
      r_lsh = src;
    end
    div_bad = (src == 32'sd0) || ((&src) && (dst == 32'sh8000_0000));

    lane_nxt        = '0;
    lane_nxt.res    = dst;
    lane_nxt.ovr    = ovr_in;
    lane_nxt.cy     = carry_in;
    case (func)
      ialu_pkg::FN_ADD: begin
        lane_nxt.res = add_w[31:0];
        lane_nxt.ovr = ovr_in | (~(src[31] ^ dst[31]) & (src[31] ^ add_w[31]));
        lane_nxt.cy  = add_w[32];
      end
      ialu_pkg::FN_SUB: begin
        lane_nxt.res = sub_w[31:0];
        lane_nxt.ovr = ovr_in | ((src[31] ^ dst[31]) & (sub_w[31] ^ dst[31]));
        lane_nxt.cy  = sub_w[32];
      end
      ialu_pkg::FN_MUL: begin
        lane_nxt.res = prod[31:0];
        lane_nxt.ovr = ovr_in | mul_ovr_w;
      end
      ialu_pkg::FN_DIV: begin
        if (div_bad) begin
          lane_nxt.ovr = 1'b1;
        end else begin
          lane_nxt.is_div = 1'b1;
          lane_nxt.neg    = src[31] ^ dst[31];
          lane_nxt.quo    = dst[31] ? (32'd0 - dst) : dst;
          lane_nxt.dvs    = src[31] ? (32'd0 - src) : src;
        end
      end
      ialu_pkg::FN_W2N: begin
        lane_nxt.res = sext_s;
        lane_nxt.ovr = ovr_in | (sext_s != src);
      end
      ialu_pkg::FN_ASH: begin
        lane_nxt.res = r_ash;
        lane_nxt.ovr = ovr_in | (r_ash[31] ^ src[31]);
      end
      ialu_pkg::FN_LSH: begin
        lane_nxt.res = r_lsh;
      end
      ialu_pkg::FN_NADD: begin
        lane_nxt.res = {{16{nadd_w[15]}}, nadd_w[15:0]};
        lane_nxt.ovr = ovr_in | (~(s16[15] ^ d16[15]) & (s16[15] ^ nadd_w[15]));
        lane_nxt.cy  = nadd_w[16];
      end
      ialu_pkg::FN_NSUB: begin
        lane_nxt.res = {{16{nsub_w[15]}}, nsub_w[15:0]};
        lane_nxt.ovr = ovr_in | ((s16[15] ^ d16[15]) & (nsub_w[15] ^ d16[15]));
        lane_nxt.cy  = nsub_w[16];
      end
      ialu_pkg::FN_NMUL: begin
        lane_nxt.res = {{16{prod[15]}}, prod[15:0]};
        lane_nxt.ovr = ovr_in | mul_ovr_n;
      end
      default: begin
        lane_nxt.res = dst;
      end
    endcase
    vld_nxt = vld_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

FILE: hdl/ialu_cell.sv
// ----------------------------------------------------------------------------
// ialu_cell
// One restoring-divide step; other lanes pass through unchanged.
// ----------------------------------------------------------------------------
module ialu_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld_in,
  input  ialu_pkg::lane_t lane_in,
  output logic            vld_r,
  output ialu_pkg::lane_t lane_r
);

  ialu_pkg::lane_t lane_nxt;
  logic [32:0]     rem_sh;
  logic [32:0]     diff;

  always_comb begin
    lane_nxt = lane_in;
    rem_sh   = {lane_in.rem, lane_in.quo[31]};
    diff     = rem_sh - {1'b0, lane_in.dvs};
    if (lane_in.is_div) begin
      if (!diff[32]) begin
        lane_nxt.rem = diff[31:0];
        lane_nxt.quo = {lane_in.quo[30:0], 1'b1};
      end else begin
        lane_nxt.rem = rem_sh[31:0];
        lane_nxt.quo = {lane_in.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

FILE: hdl/integer_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// integer_alu_with_flags_unit
// 32-bit integer ALU with carry and sticky overflow, pipelined divide chain.
// ----------------------------------------------------------------------------
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   in_ch    | sink      | func, src, dst, shift_amount, ovr_in, carry_in
//   out_ch   | source    | result, ovr_out, carry_out
//
// One item per cycle while the output is not stalled; stages: decode stage, 32 divide
// cells (one quotient bit per cell) and the output register.
// Every operation travels the full chain so results leave in order.
// Reset clears the valid bits of every stage; payload is not reset.
// A stalled output freezes the whole chain; in_ch.ready drops with it.
// ----------------------------------------------------------------------------
`include "integer_alu_with_flags_unit_defines.svh"

module integer_alu_with_flags_unit (
  input  logic           clk,
  input  logic           rst_n,
  ialu_in_if.sink        in_ch,
  ialu_out_if.source     out_ch
);

  localparam int unsigned NC = ialu_pkg::NCELL;

  logic                 adv;
  logic [NC:0]          vld_c;
  ialu_pkg::lane_t      lane_c [NC+1];
  ialu_pkg::lane_t      lane_end;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [31:0]          out_result_r;
  logic [31:0]          out_result_nxt;
  logic                 out_ovr_r;
  logic                 out_cy_r;

  // advance everything while the output slot is free or being drained
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  ialu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .vld_in       (in_ch.valid),
    .func         (in_ch.func),
    .src          (in_ch.src),
    .dst          (in_ch.dst),
    .shift_amount (in_ch.shift_amount),
    .ovr_in       (in_ch.ovr_in),
    .carry_in     (in_ch.carry_in),
    .vld_r        (vld_c[0]),
    .lane_r       (lane_c[0])
  );

  // divide chain: each cell hands its lane to the next every cycle the chain advances
  for (genvar g = 0; g < NC; g++) begin : g_cell
    ialu_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld_c[g]),
      .lane_in (lane_c[g]),
      .vld_r   (vld_c[g+1]),
      .lane_r  (lane_c[g+1])
    );
  end

  // apply the quotient sign on the way out
  always_comb begin
    lane_end      = lane_c[NC];
    out_valid_nxt = vld_c[NC];
    if (lane_end.is_div) begin
      out_result_nxt = lane_end.neg ? (32'd0 - lane_end.quo) : lane_end.quo;
    end else begin
      out_result_nxt = lane_end.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= out_result_nxt;
      out_ovr_r    <= lane_end.ovr;
      out_cy_r     <= lane_end.cy;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result    = out_result_r;
  assign out_ch.ovr_out   = out_ovr_r;
  assign out_ch.carry_out = out_cy_r;

  // a stalled chain keeps the valid bit of the decode stage and of every cell
  `IALU_ASSERT_NXT(a_stall_holds_chain, !adv, $stable(vld_c), "chain moved while stalled")
  // a transfer into the block lands in the decode stage
  `IALU_ASSERT_NXT(a_accept_lands, in_ch.valid && in_ch.ready, vld_c[0], "accepted item lost")
  // zero divisors never enter the divide chain
  `IALU_ASSERT_IMP(a_no_zero_dvs, vld_c[0] && lane_c[0].is_div, lane_c[0].dvs != 32'd0, "zero divisor in chain")

endmodule
